// File: design/twe_pkg.sv
// ----------------------------------------------------------------------------
// twe_pkg: shared definitions for the timer wheel expiry block
// Slot count, field widths, action and result codes, controller states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package twe_pkg;

    // The slot field is four bits wide, so the table holds exactly sixteen slots
    // and every slot value addresses a real entry.
    localparam int TIMERS  = 16;
    localparam int IDX_W   = $clog2(TIMERS);
    localparam int TICK_W  = 32;
    localparam int DELAY_W = 20;

    typedef enum logic [1:0] {
        ACT_START  = 2'd0,
        ACT_STOP   = 2'd1,
        ACT_TICK   = 2'd2,
        ACT_UNUSED = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        KIND_STARTED  = 3'd0,
        KIND_REJECTED = 3'd1,
        KIND_STOPPED  = 3'd2,
        KIND_EXPIRED  = 3'd3,
        KIND_NONE     = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

endpackage

// File: design/timer_wheel_expiry_top.sv
// ----------------------------------------------------------------------------
// timer_wheel_expiry_top: table of software timers with a free-running tick
// Start, stop and tick items; a tick scans the expiry memory slot by slot.
// ----------------------------------------------------------------------------
//   channel   handshake             payload
//   input     start & !busy         action, slot, delay_ticks
//   result    strobe (one cycle)    kind, slot_out, last
//
// A start or stop item is taken while idle; its result shows on the next cycle.
// A tick item scans the expiry memory one slot a cycle through its single
// read port, and it holds busy through the scan and flush states.
// The results of a tick trail the scan by one pending slot.
// Reset clears the tick count, the running flags and the controller.
// The receiver cannot stall; each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module timer_wheel_expiry_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   action,
    input  logic [twe_pkg::IDX_W-1:0]    slot,
    input  logic [twe_pkg::DELAY_W-1:0]  delay_ticks,
    output logic                         strobe,
    output logic [2:0]                   kind,
    output logic [twe_pkg::IDX_W-1:0]    slot_out,
    output logic                         last
);

    localparam int IDX_W  = twe_pkg::IDX_W;
    localparam int TICK_W = twe_pkg::TICK_W;

    // Expiry memory, one synchronous read port and one write port.
    logic [TICK_W-1:0] expiry_mem [twe_pkg::TIMERS];
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [TICK_W-1:0] mem_wdata;
    logic [IDX_W-1:0]  mem_raddr;
    logic [TICK_W-1:0] rd_data_reg;

    twe_pkg::state_t             state_reg, state_next;
    logic [TICK_W-1:0]           tick_reg, tick_next;
    logic [twe_pkg::TIMERS-1:0]  running_reg, running_next;
    logic [IDX_W:0]              issue_cnt_reg, issue_cnt_next;
    logic                        cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]            cmp_idx_reg, cmp_idx_next;
    logic                        pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]            pend_idx_reg, pend_idx_next;
    logic                        strobe_reg, strobe_next;
    logic [2:0]                  kind_reg, kind_next;
    logic [IDX_W-1:0]            slot_out_reg, slot_out_next;
    logic                        last_reg, last_next;

    logic accept;
    logic issuing;
    logic match;

    assign accept    = start && (state_reg == twe_pkg::ST_IDLE);
    assign issuing   = (issue_cnt_reg < (IDX_W+1)'(twe_pkg::TIMERS));
    assign mem_raddr = issue_cnt_reg[IDX_W-1:0];
    assign match     = cmp_valid_reg && running_reg[cmp_idx_reg] && (rd_data_reg == tick_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            expiry_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= expiry_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= twe_pkg::ST_IDLE;
            tick_reg       <= '0;
            running_reg    <= '0;
            issue_cnt_reg  <= '0;
            cmp_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tick_reg       <= tick_next;
            running_reg    <= running_next;
            issue_cnt_reg  <= issue_cnt_next;
            cmp_valid_reg  <= cmp_valid_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg  <= cmp_idx_next;
        pend_idx_reg <= pend_idx_next;
        kind_reg     <= kind_next;
        slot_out_reg <= slot_out_next;
        last_reg     <= last_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        tick_next       = tick_reg;
        running_next    = running_reg;
        issue_cnt_next  = issue_cnt_reg;
        cmp_valid_next  = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        strobe_next     = 1'b0;
        kind_next       = kind_reg;
        slot_out_next   = slot_out_reg;
        last_next       = last_reg;
        mem_we          = 1'b0;
        mem_waddr       = slot;
        mem_wdata       = tick_reg + {{(TICK_W-twe_pkg::DELAY_W){1'b0}}, delay_ticks};

        unique case (state_reg)
            twe_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (action)
                        twe_pkg::ACT_START:
                        begin
                            strobe_next   = 1'b1;
                            slot_out_next = slot;
                            last_next     = 1'b1;
                            if (running_reg[slot])
                            begin
                                kind_next = twe_pkg::KIND_REJECTED;
                            end
                            else
                            begin
                                kind_next          = twe_pkg::KIND_STARTED;
                                running_next[slot] = 1'b1;
                                mem_we             = 1'b1;
                            end
                        end
                        twe_pkg::ACT_STOP:
                        begin
                            strobe_next        = 1'b1;
                            kind_next          = twe_pkg::KIND_STOPPED;
                            slot_out_next      = slot;
                            last_next          = 1'b1;
                            running_next[slot] = 1'b0;
                        end
                        twe_pkg::ACT_TICK:
                        begin
                            tick_next       = tick_reg + 1'b1;
                            issue_cnt_next  = '0;
                            pend_valid_next = 1'b0;
                            state_next      = twe_pkg::ST_SCAN;
                        end
                        default:
                        begin
                            // The unused action code is dropped without a result.
                        end
                    endcase
                end
            end
            twe_pkg::ST_SCAN:
            begin
                if (issuing)
                begin
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = issue_cnt_reg[IDX_W-1:0];
                end
                // An expiry is held back until the next one is found, so that
                // the final result of the tick can carry the last flag.
                if (match)
                begin
                    running_next[cmp_idx_reg] = 1'b0;
                    pend_valid_next           = 1'b1;
                    pend_idx_next             = cmp_idx_reg;
                    if (pend_valid_reg)
                    begin
                        strobe_next   = 1'b1;
                        kind_next     = twe_pkg::KIND_EXPIRED;
                        slot_out_next = pend_idx_reg;
                        last_next     = 1'b0;
                    end
                end
                if (cmp_valid_reg && (cmp_idx_reg == IDX_W'(twe_pkg::TIMERS - 1)))
                begin
                    state_next = twe_pkg::ST_FLUSH;
                end
            end
            twe_pkg::ST_FLUSH:
            begin
                strobe_next = 1'b1;
                last_next   = 1'b1;
                if (pend_valid_reg)
                begin
                    kind_next     = twe_pkg::KIND_EXPIRED;
                    slot_out_next = pend_idx_reg;
                end
                else
                begin
                    kind_next     = twe_pkg::KIND_NONE;
                    slot_out_next = '0;
                end
                pend_valid_next = 1'b0;
                state_next      = twe_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = twe_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy     = (state_reg != twe_pkg::ST_IDLE);
    assign strobe   = strobe_reg;
    assign kind     = kind_reg;
    assign slot_out = slot_out_reg;
    assign last     = last_reg;

endmodule

// File: design/twe_checker.sv
// ----------------------------------------------------------------------------
// twe_assertions: port-level assertions for the timer wheel expiry block
// Checks result timing and marking against accepted items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module twe_assertions (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic [1:0]                   action,
    input logic [twe_pkg::IDX_W-1:0]    slot,
    input logic                         strobe,
    input logic [2:0]                   kind,
    input logic [twe_pkg::IDX_W-1:0]    slot_out,
    input logic                         last
);

    logic accept;

    assign accept = start && !busy;

    // A start item answers on the next cycle for the same slot.
    a_start_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && action == twe_pkg::ACT_START) |=>
            (strobe && last && slot_out == $past(slot) &&
             (kind == twe_pkg::KIND_STARTED || kind == twe_pkg::KIND_REJECTED)))
        else $error("start item not answered on the next cycle");

    a_stop_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && action == twe_pkg::ACT_STOP) |=>
            (strobe && last && kind == twe_pkg::KIND_STOPPED && slot_out == $past(slot)))
        else $error("stop item not answered on the next cycle");

    // The unused action code gives no result.
    a_unused_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && action == twe_pkg::ACT_UNUSED) |=> !strobe)
        else $error("result given for the unused action code");

    a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && kind == twe_pkg::KIND_NONE) |-> (last && slot_out == '0))
        else $error("no-expiry result malformed");

    // More results of the same tick follow, so no new item may be taken.
    a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |-> (busy && kind == twe_pkg::KIND_EXPIRED))
        else $error("non-final result while block is idle");

endmodule

bind timer_wheel_expiry_top twe_assertions u_twe_assertions (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .slot        (slot),
    .strobe      (strobe),
    .kind        (kind),
    .slot_out    (slot_out),
    .last        (last)
);
